// ===== rtl/core/recency_free_block_cache_assert.svh =====
// Assertion macros shared by the block cache RTL.
// Each macro expects signals clk and rst in the scope where it is used.
`ifndef RECENCY_FREE_BLOCK_CACHE_ASSERT_SVH
`define RECENCY_FREE_BLOCK_CACHE_ASSERT_SVH
// Checks that a condition holds at every clock edge outside reset.
`define RFBC_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rfbc assertion failed");
// Checks that one condition is followed by another on the next edge.
`define RFBC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rfbc assertion failed");
`endif

// ===== rtl/core/rfbc_pkg.sv =====
// Shared types and constants for the recency-ordered free block cache.
// No dependencies.
`default_nettype none
package rfbc_pkg;
  localparam int HANDLE_W = 48;
  localparam int SIZE_W   = 40;
  localparam int SLOP_W   = 16;
  localparam int CFG_AW   = 8;

  localparam logic [2:0] OUT_HIT       = 3'd0;
  localparam logic [2:0] OUT_MISS      = 3'd1;
  localparam logic [2:0] OUT_EVICT     = 3'd2;
  localparam logic [2:0] OUT_STORED    = 3'd3;
  localparam logic [2:0] OUT_NOTPOOLED = 3'd4;

  localparam logic [CFG_AW-1:0] CFG_POOL_BUDGET = 8'd0;
  localparam logic [CFG_AW-1:0] CFG_MIN_SIZE    = 8'd1;
  localparam logic [CFG_AW-1:0] CFG_SLOP_LIMIT  = 8'd2;
  localparam logic [CFG_AW-1:0] CFG_BYPASS      = 8'd3;

  localparam logic [SIZE_W-1:0] POOL_BUDGET_RST = 40'd524288000;
  localparam logic [SIZE_W-1:0] MIN_SIZE_RST    = 40'd3145728;
  localparam logic [SLOP_W-1:0] SLOP_LIMIT_RST  = 16'd6554;

  typedef struct packed {
    logic                func;
    logic [HANDLE_W-1:0] block_handle;
    logic [SIZE_W-1:0]   block_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          outcome;
    logic [HANDLE_W-1:0] result_handle;
    logic [SIZE_W-1:0]   result_size;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } slot_data_t;

  typedef struct packed {
    logic live;
    logic eq;
    logic fit;
  } fit_flags_t;
endpackage
`default_nettype wire

// ===== rtl/core/rfbc_slot_ram.sv =====
// Slot table memory: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module rfbc_slot_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 93,
  parameter int AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/rfbc_fit.sv =====
// Per-slot match stage for requests: exact size test and slack test.
// Depends on rfbc_pkg.
`default_nettype none
module rfbc_fit import rfbc_pkg::*; #(
  parameter int AW = 5,
  parameter int RW = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              live_in,
  input  wire logic              valid_in,
  input  wire logic [AW-1:0]     idx_in,
  input  wire logic [RW-1:0]     rank_in,
  input  wire slot_data_t        data_in,
  input  wire logic [SIZE_W-1:0] target,
  input  wire logic [SLOP_W-1:0] slop,
  output fit_flags_t             flags,
  output logic      [AW-1:0]     idx_out,
  output logic      [RW-1:0]     rank_out,
  output slot_data_t             data_out
);
  logic                     live_q;
  logic                     valid_q;
  logic                     eq_q;
  logic                     gt_q;
  logic [SIZE_W-1:0]        diff_q;
  logic [SIZE_W+SLOP_W-1:0] prod_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      live_q <= 1'b0;
    end else begin
      live_q <= live_in;
    end
    valid_q  <= valid_in;
    eq_q     <= (data_in.size == target);
    gt_q     <= (data_in.size > target);
    diff_q   <= data_in.size - target;
    prod_q   <= {{SIZE_W{1'b0}}, slop} * {{SLOP_W{1'b0}}, data_in.size};
    idx_out  <= idx_in;
    rank_out <= rank_in;
    data_out <= data_in;
  end

  // The slack test is (s - t) * 2^16 < slop * s.
  assign flags.live = live_q;
  assign flags.eq   = valid_q && eq_q;
  assign flags.fit  = valid_q && gt_q && ({diff_q, {SLOP_W{1'b0}}} < prod_q);
endmodule
`default_nettype wire

// ===== rtl/core/recency_free_block_cache.sv =====
// Top level of the recency-ordered free block cache: control sequencer,
// configuration registers and output register. Depends on rfbc_pkg,
// rfbc_slot_ram, rfbc_fit and recency_free_block_cache_assert.svh.
`default_nettype none
// Cache of up to SLOTS freed blocks kept in a single-port-read slot memory,
// one item at a time. Unless bypassed or below the minimum pooled size, a
// request reads every slot once through the match stage and then has its
// result loaded; a hit first sweeps the table again to close the age ranks.
// A release, for each evicted block, scans the table to find the oldest
// entry and reports it, then scans again to age the table, stores the block
// and reports it. Every pass is bounded by the memory's one read per cycle.
// A result sits in an output register, and the emit state waits while that
// register holds an unaccepted result. The next request is taken in the
// cycle after the last result of the previous one is loaded there.
module recency_free_block_cache import rfbc_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_item,
  input  wire logic              cfg_write,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [SIZE_W-1:0] cfg_data
);
`include "recency_free_block_cache_assert.svh"

  localparam int AW = $clog2(SLOTS);
  localparam int RW = AW;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int MW = HANDLE_W + SIZE_W + RW;

  typedef enum logic [3:0] {
    S_IDLE, S_EV_CHECK, S_EV_SCAN, S_EV_TAKE, S_AGE, S_STORE,
    S_REQ_SCAN, S_REQ_PICK, S_REQ_SWEEP, S_EMIT
  } state_t;

  state_t              state;
  state_t              ret;
  in_item_t            cur;
  out_item_t           res;
  logic [SIZE_W-1:0]   pool_budget;
  logic [SIZE_W-1:0]   min_pooled_size;
  logic [SLOP_W-1:0]   slop_limit;
  logic                bypass;
  logic [SLOTS-1:0]    valid;
  logic [SIZE_W:0]     cached_bytes;
  logic [CW-1:0]       cached_count;
  logic [AW:0]         addr;
  logic                rd_live;
  logic [AW-1:0]       rd_idx;
  logic [AW-1:0]       vic_idx;
  slot_data_t          vic_data;
  logic                free_found;
  logic [AW-1:0]       free_idx;
  logic                ex_found;
  logic [AW-1:0]       ex_idx;
  logic [RW-1:0]       ex_rank;
  slot_data_t          ex_data;
  logic                b_found;
  logic [AW-1:0]       b_idx;
  logic [RW-1:0]       b_rank;
  slot_data_t          b_data;
  logic [RW-1:0]       sel_rank;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [MW-1:0]       ram_wdata;
  logic [MW-1:0]       ram_rdata;
  slot_data_t          rd_data;
  logic [RW-1:0]       rd_rank;
  logic                scanning;
  logic                issue;
  logic                rd_last;
  logic                out_free;
  logic                ev_need;
  fit_flags_t          f_flags;
  logic [AW-1:0]       f_idx;
  logic [RW-1:0]       f_rank;
  slot_data_t          f_data;
  logic                take_ex;
  logic                take_b;
  logic [AW-1:0]       pick_idx;
  logic [RW-1:0]       pick_rank;
  slot_data_t          pick_data;

  assign rd_rank  = ram_rdata[RW-1:0];
  assign rd_data  = ram_rdata[MW-1:RW];
  assign scanning = (state == S_EV_SCAN) || (state == S_AGE) ||
                    (state == S_REQ_SCAN) || (state == S_REQ_SWEEP);
  assign issue    = scanning && (addr < (AW+1)'(SLOTS));
  assign rd_last  = rd_live && (rd_idx == AW'(SLOTS - 1));
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign ev_need  = (cached_count != '0) &&
                    (({1'b0, cached_bytes} + {2'b0, cur.block_size} > {2'b0, pool_budget}) ||
                     (cached_count == CW'(SLOTS)));

  // An exact match takes precedence over the best slack fit.
  assign take_ex   = ex_found;
  assign take_b    = !ex_found && b_found;
  assign pick_idx  = take_ex ? ex_idx : b_idx;
  assign pick_rank = take_ex ? ex_rank : b_rank;
  assign pick_data = take_ex ? ex_data : b_data;

  rfbc_slot_ram #(.DEPTH(SLOTS), .WIDTH(MW), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  rfbc_fit #(.AW(AW), .RW(RW)) u_fit (
    .clk      (clk),
    .rst      (rst),
    .live_in  (rd_live && (state == S_REQ_SCAN)),
    .valid_in (valid[rd_idx]),
    .idx_in   (rd_idx),
    .rank_in  (rd_rank),
    .data_in  (rd_data),
    .target   (cur.block_size),
    .slop     (slop_limit),
    .flags    (f_flags),
    .idx_out  (f_idx),
    .rank_out (f_rank),
    .data_out (f_data)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wdata = {rd_data, rd_rank};
    case (state)
      S_AGE: begin
        if (rd_live && valid[rd_idx]) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_data, rd_rank + RW'(1)};
        end
      end
      S_REQ_SWEEP: begin
        if (rd_live && valid[rd_idx] && (rd_rank > sel_rank)) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_data, rd_rank - RW'(1)};
        end
      end
      S_STORE: begin
        ram_we    = 1'b1;
        ram_waddr = free_idx;
        ram_wdata = {cur.block_handle, cur.block_size, {RW{1'b0}}};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ret             <= S_IDLE;
      pool_budget     <= POOL_BUDGET_RST;
      min_pooled_size <= MIN_SIZE_RST;
      slop_limit      <= SLOP_LIMIT_RST;
      bypass          <= 1'b0;
      valid           <= '0;
      cached_bytes    <= '0;
      cached_count    <= '0;
      addr            <= '0;
      rd_live         <= 1'b0;
      out_valid       <= 1'b0;
      free_found      <= 1'b0;
      ex_found        <= 1'b0;
      b_found         <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_addr)
          CFG_POOL_BUDGET: pool_budget <= cfg_data;
          CFG_MIN_SIZE:    min_pooled_size <= cfg_data;
          CFG_SLOP_LIMIT:  slop_limit <= cfg_data[SLOP_W-1:0];
          CFG_BYPASS:      bypass <= cfg_data[0];
          default:         bypass <= bypass;
        endcase
      end

      rd_live <= issue;
      rd_idx  <= addr[AW-1:0];
      if (issue) begin
        addr <= addr + (AW+1)'(1);
      end
      // The emit state reloads the output register itself.
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur  <= in_item;
            addr <= '0;
            if (bypass || (in_item.block_size < min_pooled_size)) begin
              if (in_item.func) begin
                res <= '{OUT_NOTPOOLED, in_item.block_handle, in_item.block_size, 1'b1};
              end else begin
                res <= '{OUT_MISS, '0, '0, 1'b1};
              end
              ret   <= S_IDLE;
              state <= S_EMIT;
            end else if (in_item.func) begin
              state <= S_EV_CHECK;
            end else begin
              ex_found <= 1'b0;
              b_found  <= 1'b0;
              state    <= S_REQ_SCAN;
            end
          end
        end
        S_EV_CHECK: begin
          addr       <= '0;
          free_found <= 1'b0;
          state      <= ev_need ? S_EV_SCAN : S_AGE;
        end
        S_EV_SCAN: begin
          // The oldest block always holds rank cached_count - 1.
          if (rd_live && valid[rd_idx] && (rd_rank == RW'(cached_count - CW'(1)))) begin
            vic_idx  <= rd_idx;
            vic_data <= rd_data;
          end
          if (rd_last) begin
            state <= S_EV_TAKE;
          end
        end
        S_EV_TAKE: begin
          valid[vic_idx] <= 1'b0;
          cached_bytes   <= cached_bytes - {1'b0, vic_data.size};
          cached_count   <= cached_count - CW'(1);
          res            <= '{OUT_EVICT, vic_data.handle, vic_data.size, 1'b0};
          ret            <= S_EV_CHECK;
          state          <= S_EMIT;
        end
        S_AGE: begin
          if (rd_live && !valid[rd_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= rd_idx;
          end
          if (rd_last) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          valid[free_idx] <= 1'b1;
          cached_bytes    <= cached_bytes + {1'b0, cur.block_size};
          cached_count    <= cached_count + CW'(1);
          res   <= '{OUT_STORED, cur.block_handle, cur.block_size, 1'b1};
          ret   <= S_IDLE;
          state <= S_EMIT;
        end
        S_REQ_SCAN: begin
          if (f_flags.live) begin
            if (f_flags.eq && (!ex_found || (f_rank < ex_rank))) begin
              ex_found <= 1'b1;
              ex_idx   <= f_idx;
              ex_rank  <= f_rank;
              ex_data  <= f_data;
            end
            if (f_flags.fit && (!b_found || (f_data.size < b_data.size) ||
                ((f_data.size == b_data.size) && (f_rank < b_rank)))) begin
              b_found <= 1'b1;
              b_idx   <= f_idx;
              b_rank  <= f_rank;
              b_data  <= f_data;
            end
            if (f_idx == AW'(SLOTS - 1)) begin
              state <= S_REQ_PICK;
            end
          end
        end
        S_REQ_PICK: begin
          addr <= '0;
          ret  <= S_IDLE;
          if (take_ex || take_b) begin
            valid[pick_idx] <= 1'b0;
            cached_bytes    <= cached_bytes - {1'b0, pick_data.size};
            cached_count    <= cached_count - CW'(1);
            sel_rank        <= pick_rank;
            res   <= '{OUT_HIT, pick_data.handle, pick_data.size, 1'b1};
            state <= S_REQ_SWEEP;
          end else begin
            res   <= '{OUT_MISS, '0, '0, 1'b1};
            state <= S_EMIT;
          end
        end
        S_REQ_SWEEP: begin
          if (rd_last) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_item  <= res;
            out_valid <= 1'b1;
            state     <= ret;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RFBC_ASSERT(a_count_bound, cached_count <= CW'(SLOTS))
  `RFBC_ASSERT(a_count_matches_valid, $countones(valid) == int'(cached_count))
  `RFBC_ASSERT(a_empty_no_bytes, (cached_count != '0) || (cached_bytes == '0))
  `RFBC_ASSERT_NEXT(a_store_fills, state == S_STORE, cached_count != '0)
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the recency-ordered free block cache.
// Depends on rfbc_pkg and the recency_free_block_cache top level.
`default_nettype none
module tb_top;
  import rfbc_pkg::*;

  localparam int NSLOT = 32;
  localparam int N_RANDOM = 224;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_write = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [SIZE_W-1:0] cfg_data = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  recency_free_block_cache #(.SLOTS(NSLOT)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_write(cfg_write), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // Shadow copy of the cache contents and its registers.
  logic [SIZE_W-1:0] budget_q, min_size_q;
  logic [SLOP_W-1:0] slop_q;
  logic bypass_q;
  logic [HANDLE_W-1:0] sh_handle [NSLOT];
  logic [SIZE_W-1:0] sh_size [NSLOT];
  bit sh_live [NSLOT];
  int sh_rank [NSLOT];
  logic [SIZE_W:0] sh_bytes;
  int sh_count;

  out_item_t pending_results[$];
  out_item_t last_first;
  int errors = 0;
  int results_seen = 0, hits_seen = 0, evicts_seen = 0;
  bit long_holdoff = 1'b0;
  bit no_idle = 1'b0;

  function automatic out_item_t mk(logic [2:0] oc, logic [HANDLE_W-1:0] h,
                                   logic [SIZE_W-1:0] s, logic l);
    out_item_t r;
    r.outcome = oc; r.result_handle = h; r.result_size = s; r.last = l;
    return r;
  endfunction

  task automatic shadow_reset();
    budget_q = POOL_BUDGET_RST; min_size_q = MIN_SIZE_RST;
    slop_q = SLOP_LIMIT_RST; bypass_q = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      sh_live[i] = 0; sh_rank[i] = 0; sh_handle[i] = '0; sh_size[i] = '0;
    end
    sh_bytes = '0; sh_count = 0;
  endtask

  // Applies one request to the shadow table and returns the results it causes.
  task automatic predict_cache(input in_item_t it, output out_item_t res[$]);
    logic [SIZE_W-1:0] sz;
    int old, free_i, exact, best;
    logic [SIZE_W+16:0] lhs, rhs;
    sz = it.block_size;
    res = {};
    if (bypass_q || sz < min_size_q) begin
      if (it.func) res.push_back(mk(OUT_NOTPOOLED, it.block_handle, sz, 1'b1));
      else res.push_back(mk(OUT_MISS, '0, '0, 1'b1));
      return;
    end
    if (it.func) begin
      while (sh_count > 0 && ({1'b0, sh_bytes} + sz > {2'b0, budget_q} ||
                              sh_count >= NSLOT)) begin
        old = -1;
        for (int i = 0; i < NSLOT; i++)
          if (sh_live[i] && (old < 0 || sh_rank[i] > sh_rank[old])) old = i;
        res.push_back(mk(OUT_EVICT, sh_handle[old], sh_size[old], 1'b0));
        sh_live[old] = 0;
        sh_bytes -= sh_size[old];
        sh_count--;
      end
      free_i = -1;
      for (int i = 0; i < NSLOT; i++)
        if (sh_live[i]) sh_rank[i]++;
        else if (free_i < 0) free_i = i;
      sh_handle[free_i] = it.block_handle; sh_size[free_i] = sz;
      sh_live[free_i] = 1; sh_rank[free_i] = 0;
      sh_bytes += sz; sh_count++;
      res.push_back(mk(OUT_STORED, it.block_handle, sz, 1'b1));
      return;
    end
    exact = -1; best = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (!sh_live[i]) continue;
      if (sh_size[i] == sz) begin
        if (exact < 0 || sh_rank[i] < sh_rank[exact]) exact = i;
      end else if (sh_size[i] > sz) begin
        lhs = {17'b0, sh_size[i] - sz} << 16;
        rhs = slop_q * {17'b0, sh_size[i]};
        if (lhs < rhs && (best < 0 || sh_size[i] < sh_size[best] ||
            (sh_size[i] == sh_size[best] && sh_rank[i] < sh_rank[best])))
          best = i;
      end
    end
    if (exact >= 0) best = exact;
    if (best < 0) begin
      res.push_back(mk(OUT_MISS, '0, '0, 1'b1));
      return;
    end
    for (int i = 0; i < NSLOT; i++)
      if (sh_live[i] && sh_rank[i] > sh_rank[best]) sh_rank[i]--;
    sh_live[best] = 0;
    sh_bytes -= sh_size[best];
    sh_count--;
    res.push_back(mk(OUT_HIT, sh_handle[best], sh_size[best], 1'b1));
  endtask

  // Valid stays high after acceptance until the next request or an idle gap
  // replaces it; the block stalls in the meantime.
  task automatic send(input in_item_t it);
    out_item_t res[$];
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_cache(it, res);
    if (res.size() > 0) last_first = res[0];
    foreach (res[k]) pending_results.push_back(res[k]);
  endtask

  task automatic send_checked(input in_item_t it, input bit has_exp,
                              input out_item_t exp_first);
    send(it);
    if (has_exp && last_first != exp_first) begin
      $error("directed row: table value %h, shadow value %h",
             exp_first, last_first);
      errors++;
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * NSLOT * 3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [SIZE_W-1:0] d);
    cfg_write <= 1'b1; cfg_addr <= a; cfg_data <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (a)
      CFG_POOL_BUDGET: budget_q = d;
      CFG_MIN_SIZE: min_size_q = d;
      CFG_SLOP_LIMIT: slop_q = d[SLOP_W-1:0];
      CFG_BYPASS: bypass_q = d[0];
      default: ;
    endcase
  endtask

  // Result checker and receiver stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", out_item);
        errors++;
      end else begin
        out_item_t e;
        e = pending_results.pop_front();
        results_seen++;
        if (out_item.outcome == OUT_HIT) hits_seen++;
        if (out_item.outcome == OUT_EVICT) evicts_seen++;
        if (out_item.outcome !== e.outcome) begin
          $error("outcome: expected %0d actual %0d", e.outcome, out_item.outcome); errors++;
        end
        if (out_item.result_handle !== e.result_handle) begin
          $error("result_handle: expected %h actual %h", e.result_handle,
                 out_item.result_handle); errors++;
        end
        if (out_item.result_size !== e.result_size) begin
          $error("result_size: expected %h actual %h", e.result_size,
                 out_item.result_size); errors++;
        end
        if (out_item.last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, out_item.last); errors++;
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_holdoff) begin
      out_stall <= 1'b1;
      stall_left <= 0;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      stall_left <= $urandom_range(0, 11);
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_item_t mk_in(logic f, logic [HANDLE_W-1:0] h, logic [SIZE_W-1:0] s);
    in_item_t r;
    r.func = f; r.block_handle = h; r.block_size = s;
    return r;
  endfunction

  // Sizes mostly clustered so that exact and near fits occur.
  function automatic logic [SIZE_W-1:0] pick_size();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 40'(64'd3145728 + 64'($urandom_range(0, 7)) * 64'd1048576);
    if (sel < 8) return 40'(64'd3145728 + 64'($urandom_range(0, 600000)));
    if (sel == 8) return 40'({$urandom, $urandom});
    return 40'($urandom_range(0, 3145727));
  endfunction

  typedef struct {
    in_item_t it;
    bit has_exp;
    out_item_t exp_first;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    logic [HANDLE_W-1:0] recent_h[$];
    logic [SIZE_W-1:0] recent_s[$];
    in_item_t it;
    logic [SIZE_W-1:0] s;
    shadow_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    rows.push_back('{mk_in(1'b0, '0, 40'd8388608), 1'b1, mk(OUT_MISS, '0, '0, 1'b1)});
    rows.push_back('{mk_in(1'b1, 48'hFFFF_FFFF_FFFF, 40'd0), 1'b1,
                     mk(OUT_NOTPOOLED, 48'hFFFF_FFFF_FFFF, 40'd0, 1'b1)});
    rows.push_back('{mk_in(1'b1, 48'h1, 40'd4194304), 1'b1,
                     mk(OUT_STORED, 48'h1, 40'd4194304, 1'b1)});
    rows.push_back('{mk_in(1'b1, 48'h1, 40'd4194304), 1'b0, '0});
    rows.push_back('{mk_in(1'b1, 48'h2, 40'd4500000), 1'b0, '0});
    rows.push_back('{mk_in(1'b0, 48'hFFFF_FFFF_FFFF, 40'd4194304), 1'b0, '0});
    rows.push_back('{mk_in(1'b0, '0, 40'd4194000), 1'b0, '0});
    rows.push_back('{mk_in(1'b0, '0, 40'd4194304), 1'b0, '0});
    rows.push_back('{mk_in(1'b0, '0, 40'd3145727), 1'b1, mk(OUT_MISS, '0, '0, 1'b1)});
    rows.push_back('{mk_in(1'b1, 48'h3, 40'hFF_FFFF_FFFF), 1'b0, '0});
    rows.push_back('{mk_in(1'b1, 48'hAAAA_5555_AAAA, 40'd3145728), 1'b0, '0});
    rows.push_back('{mk_in(1'b1, 48'h5555_AAAA_5555, 40'd3145728), 1'b0, '0});
    rows.push_back('{mk_in(1'b0, '0, 40'hFF_FFFF_FFFF), 1'b0, '0});
    foreach (rows[k]) send_checked(rows[k].it, rows[k].has_exp, rows[k].exp_first);
    // Fill past the table size to force capacity evictions.
    no_idle = 1'b1;
    for (int k = 0; k < 40; k++) send(mk_in(1'b1, 48'(k + 100), 40'd3145728));
    no_idle = 1'b0;
    in_valid <= 1'b0;
    wait_drained();

    // Random phases across register settings, extremes included.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin write_reg(CFG_SLOP_LIMIT, 40'hFFFF); write_reg(CFG_POOL_BUDGET, 40'd60000000); end
        1: begin write_reg(CFG_SLOP_LIMIT, '0); write_reg(CFG_MIN_SIZE, '0); end
        2: begin write_reg(CFG_BYPASS, 40'd1); end
        3: begin write_reg(CFG_BYPASS, '0); write_reg(CFG_POOL_BUDGET, 40'hFF_FFFF_FFFF);
                 write_reg(CFG_MIN_SIZE, 40'hFF_FFFF_FFFF); end
        4: begin write_reg(CFG_POOL_BUDGET, '0); write_reg(CFG_MIN_SIZE, 40'd3145728);
                 write_reg(8'd9, 40'd1); end
        5: begin write_reg(CFG_POOL_BUDGET, 40'd524288000); write_reg(CFG_SLOP_LIMIT, 40'd6554); end
        default: begin write_reg(CFG_SLOP_LIMIT, 40'd30000); write_reg(CFG_POOL_BUDGET, 40'd30000000); end
      endcase
      if (ph == 5) begin
        long_holdoff = 1'b1;
        fork
          begin repeat (600) @(posedge clk); long_holdoff = 1'b0; end
        join_none
      end
      for (int k = 0; k < N_RANDOM / 7; k++) begin
        no_idle = (k % 20) >= 15;
        if ($urandom_range(0, 1)) begin
          s = pick_size();
          it = mk_in(1'b1, 48'({$urandom, $urandom}), s);
          if ($urandom_range(0, 3) == 0 && recent_h.size() > 0)
            it.block_handle = recent_h[$urandom_range(0, recent_h.size() - 1)];
          recent_h.push_back(it.block_handle); recent_s.push_back(s);
        end else begin
          it = mk_in(1'b0, 48'({$urandom, $urandom}), pick_size());
          if ($urandom_range(0, 1) && recent_s.size() > 0) begin
            s = recent_s[$urandom_range(0, recent_s.size() - 1)];
            it.block_size = s - 40'($urandom_range(0, 3) * $urandom_range(0, 200000));
          end
        end
        send(it);
      end
      no_idle = 1'b0;
      in_valid <= 1'b0;
      wait (!long_holdoff);
      wait_drained();
    end

    $display("Checked %0d results (%0d hits, %0d evictions) over 7 register settings,",
             results_seen, hits_seen, evicts_seen);
    $display("including bypass, zero budget, full slop and a long output hold-off.");
    if (errors == 0 && pending_results.size() == 0)
      $display("recency_free_block_cache verification clean");
    else
      $display("recency_free_block_cache verification failed");
    $finish;
  end

  initial begin
    #40000000;
    $display("recency_free_block_cache verification failed");
    $finish;
  end
endmodule
`default_nettype wire
